### rtl/tensor_transpose_address_map_core_assert.svh
// Assertion macros for the transpose address map.
// Included by rtl/tensor_transpose_address_map_core.sv; depends on nothing else.
`ifndef TENSOR_TRANSPOSE_ADDRESS_MAP_CORE_ASSERT_SVH
`define TENSOR_TRANSPOSE_ADDRESS_MAP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTAM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold after the antecedent, delayed by dly.
`define TTAM_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

### rtl/ttam_pkg.sv
// Shared widths, codes and helper function of the transpose address map.
// Depends on nothing; used by rtl/tensor_transpose_address_map_core.sv.
package ttam_pkg;

   localparam int MAX_RANK      = 4;
   localparam int INDEX_BITS    = 24;
   localparam int NUM_DIMS      = 4;
   localparam int AXIS_SEL_BITS = 2;
   localparam int DIM_BITS      = 13;
   localparam int RANK_BITS     = 3;
   localparam int ORDER_BITS    = NUM_DIMS * AXIS_SEL_BITS;
   localparam int CNT_BITS      = INDEX_BITS + 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = DIM_BITS;
   localparam int STATUS_BITS   = 2;

   typedef logic [INDEX_BITS-1:0]                 index_type;
   typedef logic [DIM_BITS-1:0]                   dim_type;
   typedef logic [NUM_DIMS-1:0][DIM_BITS-1:0]     dim_vec_type;
   typedef logic [CNT_BITS-1:0]                   cnt_type;
   typedef logic [AXIS_SEL_BITS-1:0]              axis_type;
   typedef logic [RANK_BITS-1:0]                  rank_type;
   typedef logic [ORDER_BITS-1:0]                 order_type;
   typedef logic [CSR_IDX_BITS-1:0]               csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0]              csr_data_type;
   typedef logic [STATUS_BITS-1:0]                status_type;

   // Register indexes on the configuration port.
   localparam csr_idx_type CSR_RANK  = 3'd0;
   localparam csr_idx_type CSR_DIM0  = 3'd1;
   localparam csr_idx_type CSR_DIM1  = 3'd2;
   localparam csr_idx_type CSR_DIM2  = 3'd3;
   localparam csr_idx_type CSR_DIM3  = 3'd4;
   localparam csr_idx_type CSR_ORDER = 3'd5;

   // Result status codes.
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_RANGE   = 2'd1;
   localparam status_type ST_BAD_CFG = 2'd2;

   // Reset values of the configuration.
   localparam rank_type  RANK_RESET  = 3'd4;
   localparam dim_type   DIM_RESET   = 13'd1;
   localparam order_type ORDER_RESET = 8'd228;

   // Element count limit and the saturated value that stands for "too large".
   localparam cnt_type INDEX_LIMIT = cnt_type'(1) << INDEX_BITS;
   localparam cnt_type COUNT_SAT   = INDEX_LIMIT + cnt_type'(1);

   // Saturating product of a running element count and one axis size.
   function automatic cnt_type sat_mul(input cnt_type p, input dim_type d);
      logic [CNT_BITS+DIM_BITS-1:0] full;
      full = {{DIM_BITS{1'b0}}, p} * {{CNT_BITS{1'b0}}, d};
      if (full > (CNT_BITS+DIM_BITS)'(INDEX_LIMIT)) begin
         return COUNT_SAT;
      end
      return full[CNT_BITS-1:0];
   endfunction

endpackage

### rtl/tensor_transpose_address_map_core.sv
// Top level of the transpose address map: configuration, divider pipeline, weighting.
// Depends on rtl/ttam_pkg.sv and rtl/tensor_transpose_address_map_core_assert.svh.

// The block turns a flat row-major index into a transposed tensor into the flat
// index of the same element in the source tensor. It takes one beat on every
// cycle in which start is high and busy is low, and busy is high only while
// reset is held, so a new index may be offered in every cycle. Each result beat
// is shown on the rsp_ ports for exactly one cycle, marked by rsp_valid, and
// results leave in the order their indexes arrived. The receiver has no way to
// hold results off and must take every strobed beat. Each index passes through
// the divider pipeline, which peels the three inner output coordinates off the
// index with restoring division, four quotient bits per stage, six stages per
// axis, followed by one stage for the range check, one for the stride multiplies
// and two for the sum. Configuration writes are taken at once and apply to every
// beat started from the next cycle on; the strides and element counts derived
// from them settle well before a beat reaches the stages that use them.
`include "tensor_transpose_address_map_core_assert.svh"

module tensor_transpose_address_map_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ttam_pkg::index_type   req_out_index,
   output logic                  rsp_valid,
   output ttam_pkg::index_type   rsp_in_index,
   output ttam_pkg::status_type  rsp_status,
   input  logic                  csr_we,
   input  ttam_pkg::csr_idx_type csr_index,
   input  ttam_pkg::csr_data_type csr_wdata
);
   import ttam_pkg::*;

   // Quotient bits resolved per divider stage.
   localparam int BPS          = 4;
   localparam int SPD          = (INDEX_BITS + BPS - 1) / BPS;
   localparam int NUM_DIVS     = NUM_DIMS - 1;
   localparam int DS           = NUM_DIVS * SPD;
   // Edges from the accepting edge to the edge at which the result is taken.
   localparam int PIPE_LATENCY = DS + 5;

   typedef logic [NUM_DIMS-1:1][DIM_BITS-1:0] crd_type;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   rank_type    rank_ff;
   dim_vec_type dims_ff;
   order_type   order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= RANK_RESET;
         dims_ff  <= {NUM_DIMS{DIM_RESET}};
         order_ff <= ORDER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RANK:  rank_ff    <= csr_wdata[RANK_BITS-1:0];
            CSR_DIM0:  dims_ff[0] <= csr_wdata;
            CSR_DIM1:  dims_ff[1] <= csr_wdata;
            CSR_DIM2:  dims_ff[2] <= csr_wdata;
            CSR_DIM3:  dims_ff[3] <= csr_wdata;
            CSR_ORDER: order_ff   <= csr_wdata[ORDER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign busy = reset;

   // ------------------------------------------------------------------
   // Derived configuration. The shape is padded on the outer side with
   // axes of size one, so that every rank maps onto the same four-axis
   // datapath; row-major order is unchanged by leading unit axes.
   // ------------------------------------------------------------------
   logic                          rank_ok_in, rank_ok_ff;
   logic                          perm_bad_in, perm_bad_ff;
   dim_vec_type                   src_p_in, src_p_ff;
   dim_vec_type                   osz_p_in, osz_p_ff;
   logic [NUM_DIMS-1:0][AXIS_SEL_BITS-1:0] perm_p_in, perm_p_ff;

   always_comb begin
      axis_type pad;
      axis_type k;
      axis_type src;
      rank_ok_in  = (rank_ff != '0) && (int'(rank_ff) <= MAX_RANK) &&
                    (int'(rank_ff) <= NUM_DIMS);
      pad         = AXIS_SEL_BITS'(NUM_DIMS - int'(rank_ff));
      perm_bad_in = 1'b0;
      for (int j = 0; j < NUM_DIMS; j++) begin
         k   = AXIS_SEL_BITS'(j - int'(pad));
         src = order_ff[k*AXIS_SEL_BITS +: AXIS_SEL_BITS];
         if (j < int'(pad)) begin
            src_p_in[j]  = DIM_RESET;
            osz_p_in[j]  = DIM_RESET;
            perm_p_in[j] = AXIS_SEL_BITS'(j);
         end else begin
            if ({1'b0, src} >= rank_ff) begin
               perm_bad_in = 1'b1;
            end
            src_p_in[j]  = dims_ff[k];
            osz_p_in[j]  = dims_ff[src];
            perm_p_in[j] = src + pad;
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ok_ff  <= rank_ok_in;
      perm_bad_ff <= perm_bad_in;
      src_p_ff    <= src_p_in;
      osz_p_ff    <= osz_p_in;
      perm_p_ff   <= perm_p_in;
   end

   // Running products from the inner axis outwards, one multiply per register.
   // src_c_ff[i] is the saturated product of padded source sizes i and inward,
   // so src_c_ff[i+1] is the row-major stride of source axis i.
   cnt_type src_c_ff [NUM_DIMS];
   cnt_type out_c_ff [NUM_DIMS];

   always_ff @(posedge clock) begin
      src_c_ff[NUM_DIMS-1] <= {{(CNT_BITS-DIM_BITS){1'b0}}, src_p_ff[NUM_DIMS-1]};
      out_c_ff[NUM_DIMS-1] <= {{(CNT_BITS-DIM_BITS){1'b0}}, osz_p_ff[NUM_DIMS-1]};
      for (int i = 0; i < NUM_DIMS - 1; i++) begin
         src_c_ff[i] <= sat_mul(src_c_ff[i+1], src_p_ff[i]);
         out_c_ff[i] <= sat_mul(out_c_ff[i+1], osz_p_ff[i]);
      end
   end

   logic      cfg_bad_ff;
   logic      out_zero_ff;
   index_type w_in [NUM_DIMS];
   index_type w_ff [NUM_DIMS];

   always_comb begin
      for (int j = 0; j < NUM_DIMS; j++) begin
         w_in[j] = index_type'(1);
         for (int i = 0; i < NUM_DIMS - 1; i++) begin
            if (int'(perm_p_ff[j]) == i) begin
               w_in[j] = src_c_ff[i+1][INDEX_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cfg_bad_ff  <= !rank_ok_ff || perm_bad_ff || (src_c_ff[0] > INDEX_LIMIT) ||
                     (out_c_ff[0] > INDEX_LIMIT);
      out_zero_ff <= (out_c_ff[0] == '0);
      w_ff        <= w_in;
   end

   // ------------------------------------------------------------------
   // Divider pipeline. The index shifts left through num while quotient bits
   // fill in from the bottom, so after each division num already holds the
   // dividend for the next one; only the remainder restarts from zero, and
   // the finished remainder is kept as the coordinate of that axis.
   // ------------------------------------------------------------------
   logic      vld_ff [DS+4];
   index_type num_ff [DS+1];
   dim_type   rem_ff [DS+1];
   crd_type   crd_ff [DS+1];
   index_type num_in [DS];
   dim_type   rem_in [DS];
   crd_type   crd_in [DS];

   always_comb begin
      index_type           num_v;
      dim_type             rem_v;
      dim_type             div_v;
      logic [DIM_BITS:0]   trial_v;
      int                  save_v;
      for (int g = 0; g < DS; g++) begin
         num_v  = num_ff[g];
         rem_v  = rem_ff[g];
         crd_in[g] = crd_ff[g];
         div_v  = osz_p_ff[NUM_DIMS - 1 - g / SPD];
         save_v = (g >= SPD) ? NUM_DIMS - g / SPD : NUM_DIMS - 1;
         if ((g % SPD == 0) && (g >= SPD)) begin
            crd_in[g][save_v] = rem_ff[g];
            rem_v = '0;
         end
         for (int k = 0; k < BPS; k++) begin
            if ((g % SPD) * BPS + k < INDEX_BITS) begin
               trial_v = {rem_v, num_v[INDEX_BITS-1]};
               num_v   = {num_v[INDEX_BITS-2:0], 1'b0};
               if (trial_v >= {1'b0, div_v}) begin
                  trial_v  = trial_v - {1'b0, div_v};
                  num_v[0] = 1'b1;
               end
               rem_v = trial_v[DIM_BITS-1:0];
            end
         end
         num_in[g] = num_v;
         rem_in[g] = rem_v;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= req_out_index;
      rem_ff[0] <= '0;
      crd_ff[0] <= '0;
      for (int g = 0; g < DS; g++) begin
         num_ff[g+1] <= num_in[g];
         rem_ff[g+1] <= rem_in[g];
         crd_ff[g+1] <= crd_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DS + 4; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start && !busy;
         for (int s = 1; s < DS + 4; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Tail: range check, stride weighting and sum. The outermost coordinate is
   // the final quotient; the index lies inside the tensor exactly when that
   // quotient is below the outermost padded output size.
   // ------------------------------------------------------------------
   dim_type    coord_ff [NUM_DIMS];
   status_type st_in;
   status_type st1_ff, st2_ff, st3_ff;
   logic [DIM_BITS+INDEX_BITS-1:0] prod_full [NUM_DIMS];
   index_type  prod_ff [NUM_DIMS];
   index_type  psum_ff [2];
   index_type  rsp_in_index_ff;
   status_type rsp_status_ff;
   logic       rsp_valid_ff;

   always_comb begin
      if (cfg_bad_ff) begin
         st_in = ST_BAD_CFG;
      end else if (out_zero_ff ||
                   (num_ff[DS] >= {{(INDEX_BITS-DIM_BITS){1'b0}}, osz_p_ff[0]})) begin
         st_in = ST_RANGE;
      end else begin
         st_in = ST_OK;
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_DIMS; j++) begin
         prod_full[j] = {{INDEX_BITS{1'b0}}, coord_ff[j]} * {{DIM_BITS{1'b0}}, w_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      coord_ff[0] <= num_ff[DS][DIM_BITS-1:0];
      coord_ff[1] <= rem_ff[DS];
      for (int j = 2; j < NUM_DIMS; j++) begin
         coord_ff[j] <= crd_ff[DS][j];
      end
      st1_ff <= st_in;
      for (int j = 0; j < NUM_DIMS; j++) begin
         prod_ff[j] <= prod_full[j][INDEX_BITS-1:0];
      end
      st2_ff     <= st1_ff;
      psum_ff[0] <= index_type'(prod_ff[0] + prod_ff[1]);
      psum_ff[1] <= index_type'(prod_ff[2] + prod_ff[3]);
      st3_ff     <= st2_ff;
      rsp_in_index_ff <= (st3_ff == ST_OK) ? index_type'(psum_ff[0] + psum_ff[1]) : '0;
      rsp_status_ff   <= st3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DS+3];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_index = rsp_in_index_ff;
   assign rsp_status   = rsp_status_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `TTAM_ASSERT_DELAY(a_result_follows_start, clock, reset, start && !busy, PIPE_LATENCY, rsp_valid, "accepted beat produced no result at the expected cycle")
   `TTAM_ASSERT_IMPL(a_result_has_start, clock, reset, rsp_valid, $past(start && !busy, PIPE_LATENCY), "result beat without a matching start beat")
   `TTAM_ASSERT_IMPL(a_error_zero_index, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_in_index == '0, "error result carries a nonzero index")
   `TTAM_ASSERT_IMPL(a_bad_cfg_status, clock, reset, rsp_valid && cfg_bad_ff, rsp_status == ST_BAD_CFG, "bad configuration not reported")

endmodule
